>>> rtl/core/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the stereo ping-pong echo.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 18;
   localparam int DELAY_W  = 16;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_DELAY_LEFT  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_RIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_LEFT   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_RIGHT  = 2'd3;

   localparam int DELAY_RESET = 24000;
   localparam logic signed [GAIN_W-1:0] GAIN_RESET = 18'sd32768;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_L,
      BK_SUM_L,
      BK_MUL_R,
      BK_SUM_R
   } spp_back_state_type;

endpackage

>>> rtl/core/spp_stream_if.sv
// ----------------------------------------------------------------------------
// spp_req_if / spp_rsp_if
// Valid/ready stream channels carrying one stereo sample pair.
// ----------------------------------------------------------------------------
interface spp_req_if import spp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface spp_rsp_if import spp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/core/spp_delay_mod.sv
// ----------------------------------------------------------------------------
// spp_delay_mod
// Reduces a written delay modulo the store depth by reciprocal
// multiplication: a quotient estimate, its remainder, then a final correction.
// ----------------------------------------------------------------------------
module spp_delay_mod import spp_pkg::*; #(
   parameter int DEPTH = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DELAY_W-1:0]         value,
   output logic                       busy,
   output logic [$clog2(DEPTH)-1:0]   result
);

   localparam int AW = $clog2(DEPTH);
   localparam int RW = 33;
   localparam int PW = DELAY_W + RW;
   localparam int QW = PW - 32;
   localparam int MW = 40;
   localparam logic [RW-1:0] RECIP        = RW'((64'd1 << 32) / 64'(DEPTH));
   localparam logic [MW-1:0] DEPTH_M      = MW'(DEPTH);
   localparam logic [AW-1:0] RESET_RESULT = AW'(DELAY_RESET % DEPTH);

   logic                busy_ff, busy_in;
   logic                quo_vld_ff, quo_vld_in;
   logic                rem_vld_ff, rem_vld_in;
   logic [DELAY_W-1:0]  val_ff, val_in;
   logic [QW-1:0]       quo_ff, quo_in;
   logic [DELAY_W:0]    rem_ff, rem_in;
   logic [AW-1:0]       result_ff, result_in;
   logic [PW-1:0]       prod;
   logic [MW-1:0]       quo_depth;
   logic [MW-1:0]       diff;
   logic [AW-1:0]       rem_fixed;

   // The quotient estimate from the truncated reciprocal is exact or one low,
   // so a single compare and subtract finishes the remainder.
   always_comb begin
      prod      = PW'(val_ff) * PW'(RECIP);
      quo_in    = prod[PW-1:32];
      quo_depth = MW'(quo_ff) * DEPTH_M;
      diff      = MW'(val_ff) - quo_depth;
      rem_in    = diff[DELAY_W:0];
      if (MW'(rem_ff) >= DEPTH_M) begin
         rem_fixed = AW'(MW'(rem_ff) - DEPTH_M);
      end else begin
         rem_fixed = AW'(rem_ff);
      end
      busy_in    = busy_ff;
      quo_vld_in = 1'b0;
      rem_vld_in = 1'b0;
      val_in     = val_ff;
      result_in  = result_ff;
      if (start) begin
         busy_in = 1'b1;
         val_in  = value;
      end else if (busy_ff) begin
         if (rem_vld_ff) begin
            busy_in   = 1'b0;
            result_in = rem_fixed;
         end else if (quo_vld_ff) begin
            rem_vld_in = 1'b1;
         end else begin
            quo_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         quo_vld_ff <= 1'b0;
         rem_vld_ff <= 1'b0;
         result_ff  <= RESET_RESULT;
      end else begin
         busy_ff    <= busy_in;
         quo_vld_ff <= quo_vld_in;
         rem_vld_ff <= rem_vld_in;
         result_ff  <= result_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy   = busy_ff;
   assign result = result_ff;

endmodule

>>> rtl/core/spp_front.sv
// ----------------------------------------------------------------------------
// spp_front
// Accepts sample pairs, tracks the write position and works out both
// read positions, their fill status and the forwarding case.
// ----------------------------------------------------------------------------
module spp_front import spp_pkg::*; #(
   parameter int DEPTH = 65536
) (
   input  logic                                   clock,
   input  logic                                   reset,
   spp_req_if.sink                                req,
   input  logic                                   cfg_busy,
   input  logic [$clog2(DEPTH)-1:0]               delay_left,
   input  logic [$clog2(DEPTH)-1:0]               delay_right,
   input  logic                                   q_full,
   output logic                                   push_valid,
   output logic [2*SAMPLE_W+3*$clog2(DEPTH)+2:0]  push_data
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

   logic [AW-1:0] pos_ff, pos_in;
   logic          wrapped_ff, wrapped_in;
   logic [AW-1:0] next_pos;
   logic [AW:0]   diff_l, diff_r;
   logic [AW-1:0] idx_l, idx_r;
   logic          valid_l, valid_r, fwd;
   logic          accept;

   assign req.ready = !cfg_busy && !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      next_pos = (pos_ff == LAST) ? '0 : pos_ff + AW'(1);
      diff_l   = {1'b0, pos_ff} - {1'b0, delay_left};
      diff_r   = {1'b0, next_pos} - {1'b0, delay_right};
      idx_l    = diff_l[AW] ? AW'(diff_l + DEPTH_X) : diff_l[AW-1:0];
      idx_r    = diff_r[AW] ? AW'(diff_r + DEPTH_X) : diff_r[AW-1:0];
      // Until the position first wraps, only entries below it hold data; a read of
      // the left store may also take the position itself, forwarded from the left output.
      valid_l  = wrapped_ff || (idx_l < pos_ff);
      valid_r  = wrapped_ff || (idx_r <= pos_ff);
      fwd      = (idx_r == pos_ff);
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         pos_in = next_pos;
         if (pos_ff == LAST) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign push_valid = accept;
   assign push_data  = {req.left_in, req.right_in, pos_ff, idx_l, idx_r,
                        valid_l, valid_r, fwd};

endmodule

>>> rtl/core/spp_queue.sv
// ----------------------------------------------------------------------------
// spp_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module spp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/spp_back.sv
// ----------------------------------------------------------------------------
// spp_back
// Reads both stores, forms the two feedback products, rounds and saturates
// the outputs, writes them back and presents the result pair.
// ----------------------------------------------------------------------------
module spp_back import spp_pkg::*; #(
   parameter int DEPTH = 65536
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  logic [2*SAMPLE_W+3*$clog2(DEPTH)+2:0]  q_data,
   output logic                                   q_pop,
   input  logic signed [GAIN_W-1:0]               gain_left,
   input  logic signed [GAIN_W-1:0]               gain_right,
   spp_rsp_if.source                              rsp
);

   localparam int AW = $clog2(DEPTH);

   spp_back_state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] left_mem  [DEPTH];
   logic signed [SAMPLE_W-1:0] right_mem [DEPTH];

   logic signed [SAMPLE_W-1:0] q_lin, q_rin;
   logic [AW-1:0]              q_pos, q_idx_l, q_idx_r;

   logic signed [SAMPLE_W-1:0] lin_ff, rin_ff;
   logic [AW-1:0]              pos_ff;
   logic                       valid_l_ff, valid_r_ff, fwd_ff;
   logic signed [SAMPLE_W-1:0] rd_left_ff, rd_right_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] lout_ff;
   logic signed [SAMPLE_W-1:0] left_out_ff, right_out_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       rd_en, wr_left, wr_right, load_out, load_mul;
   logic                       out_free;
   logic signed [GAIN_W-1:0]   mul_gain;
   logic signed [SAMPLE_W-1:0] mul_sample;
   logic signed [SAMPLE_W-1:0] mix_sample;
   logic signed [SAMPLE_W-1:0] mix_out;

   // Round half up after the 16-bit shift, then clamp to the sample range.
   function automatic logic signed [SAMPLE_W-1:0] mix(
      input logic signed [SAMPLE_W-1:0] s,
      input logic signed [PROD_W-1:0]   p
   );
      logic signed [PROD_W+1:0] acc;
      logic signed [27:0]       q;
      acc = {{4{s[SAMPLE_W-1]}}, s, 16'b0} - {{2{p[PROD_W-1]}}, p}
            + (PROD_W+2)'(32768);
      q   = acc[PROD_W+1:16];
      if (q > 28'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end else if (q < 28'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   assign q_idx_r = q_data[3 +: AW];
   assign q_idx_l = q_data[3+AW +: AW];
   assign q_pos   = q_data[3+2*AW +: AW];
   assign q_rin   = q_data[3+3*AW +: SAMPLE_W];
   assign q_lin   = q_data[3+3*AW+SAMPLE_W +: SAMPLE_W];

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      wr_left  = 1'b0;
      wr_right = 1'b0;
      load_out = 1'b0;
      load_mul = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               state_in = BK_MUL_L;
            end
         end
         BK_MUL_L: begin
            load_mul = 1'b1;
            state_in = BK_SUM_L;
         end
         BK_SUM_L: begin
            wr_left  = 1'b1;
            state_in = BK_MUL_R;
         end
         BK_MUL_R: begin
            load_mul = 1'b1;
            state_in = BK_SUM_R;
         end
         BK_SUM_R: begin
            if (out_free) begin
               wr_right = 1'b1;
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == BK_MUL_L) begin
         mul_gain   = gain_left;
         mul_sample = valid_l_ff ? rd_right_ff : '0;
      end else begin
         mul_gain = gain_right;
         // A right read at the current position wants the left output just made.
         if (fwd_ff) begin
            mul_sample = lout_ff;
         end else begin
            mul_sample = valid_r_ff ? rd_left_ff : '0;
         end
      end
      prod_in    = mul_gain * mul_sample;
      mix_sample = (state_ff == BK_SUM_L) ? lin_ff : rin_ff;
      mix_out    = mix(mix_sample, prod_ff);
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         lin_ff     <= q_lin;
         rin_ff     <= q_rin;
         pos_ff     <= q_pos;
         valid_l_ff <= q_data[2];
         valid_r_ff <= q_data[1];
         fwd_ff     <= q_data[0];
      end
      if (load_mul) begin
         prod_ff <= prod_in;
      end
      if (wr_left) begin
         lout_ff <= mix_out;
      end
      if (load_out) begin
         left_out_ff  <= lout_ff;
         right_out_ff <= mix_out;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_left) begin
         left_mem[pos_ff] <= mix_out;
      end
      if (rd_en) begin
         rd_left_ff <= left_mem[q_idx_r];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_right) begin
         right_mem[pos_ff] <= mix_out;
      end
      if (rd_en) begin
         rd_right_ff <= right_mem[q_idx_l];
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.left_out  = left_out_ff;
   assign rsp.right_out = right_out_ff;

endmodule

>>> rtl/core/stereo_ping_pong_echo.sv
// ----------------------------------------------------------------------------
// stereo_ping_pong_echo
// Cross-coupled stereo echo with two circular sample stores.
//
// Each req_ch transaction carries one Q1.23 stereo pair; each rsp_ch
// transaction returns the saturated output pair, one per input, in order.
// The front takes a pair in any cycle its two-entry queue has room and no
// delay reduction runs; a waiting result holds the sender only once it fills.
// The back handles one pair at a time: a read of both stores, then multiply
// and sum for the left channel and again for the right, and the result pair
// goes to the output register; it pops the next pair only once idle again.
// When rsp_ch stalls, the finished pair waits in the output register and
// the back holds its last step; the queue then fills and req_ch.ready drops.
// Writing a delay register starts a reduction modulo the store
// depth, during which req_ch.ready is low.
// Reset clears the write position and control state. The stores are not
// swept: entries not yet written since reset read as zero through fill
// tracking of the write position.
// ----------------------------------------------------------------------------
module stereo_ping_pong_echo import spp_pkg::*; #(
   parameter int BUFFER_DEPTH = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   spp_req_if.sink               req_ch,
   spp_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int IW = 2*SAMPLE_W + 3*AW + 3;

   logic [DELAY_W-1:0]       delay_left_ff, delay_left_in;
   logic [DELAY_W-1:0]       delay_right_ff, delay_right_in;
   logic signed [GAIN_W-1:0] gain_left_ff, gain_left_in;
   logic signed [GAIN_W-1:0] gain_right_ff, gain_right_in;

   logic                 csr_write;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 start_l, start_r, busy_l, busy_r;
   logic [AW-1:0]        dist_l, dist_r;

   logic                 push_valid, q_full, q_valid, q_pop;
   logic [IW-1:0]        push_data, q_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign start_l    = csr_write && (reg_idx == REG_DELAY_LEFT);
   assign start_r    = csr_write && (reg_idx == REG_DELAY_RIGHT);

   always_comb begin
      delay_left_in  = delay_left_ff;
      delay_right_in = delay_right_ff;
      gain_left_in   = gain_left_ff;
      gain_right_in  = gain_right_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_DELAY_LEFT:  delay_left_in  = csr_pwdata[DELAY_W-1:0];
            REG_DELAY_RIGHT: delay_right_in = csr_pwdata[DELAY_W-1:0];
            REG_GAIN_LEFT:   gain_left_in   = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_RIGHT:  gain_right_in  = csr_pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
      case (reg_idx)
         REG_DELAY_LEFT:  csr_prdata = CSR_DATA_W'(delay_left_ff);
         REG_DELAY_RIGHT: csr_prdata = CSR_DATA_W'(delay_right_ff);
         REG_GAIN_LEFT:   csr_prdata = CSR_DATA_W'(gain_left_ff);
         REG_GAIN_RIGHT:  csr_prdata = CSR_DATA_W'(gain_right_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff  <= DELAY_W'(DELAY_RESET);
         delay_right_ff <= DELAY_W'(DELAY_RESET);
         gain_left_ff   <= GAIN_RESET;
         gain_right_ff  <= GAIN_RESET;
      end else begin
         delay_left_ff  <= delay_left_in;
         delay_right_ff <= delay_right_in;
         gain_left_ff   <= gain_left_in;
         gain_right_ff  <= gain_right_in;
      end
   end

   spp_delay_mod #(.DEPTH(BUFFER_DEPTH)) u_mod_left (
      .clock  (clock),
      .reset  (reset),
      .start  (start_l),
      .value  (csr_pwdata[DELAY_W-1:0]),
      .busy   (busy_l),
      .result (dist_l)
   );

   spp_delay_mod #(.DEPTH(BUFFER_DEPTH)) u_mod_right (
      .clock  (clock),
      .reset  (reset),
      .start  (start_r),
      .value  (csr_pwdata[DELAY_W-1:0]),
      .busy   (busy_r),
      .result (dist_r)
   );

   spp_front #(.DEPTH(BUFFER_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .cfg_busy    (busy_l || busy_r),
      .delay_left  (dist_l),
      .delay_right (dist_r),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   spp_queue #(.WIDTH(IW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   spp_back #(.DEPTH(BUFFER_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .gain_left  (gain_left_ff),
      .gain_right (gain_right_ff),
      .rsp        (rsp_ch)
   );

endmodule
